FILE: rtl/core/byte_memory_sized_access_top_assert.svh
// Assertion helpers for the byte memory block.
// Both expect clk in the scope of use; BMA_ASSERT also expects rst_n.
`ifndef BYTE_MEMORY_SIZED_ACCESS_TOP_ASSERT_SVH
`define BYTE_MEMORY_SIZED_ACCESS_TOP_ASSERT_SVH

// Checked only out of reset.
`define BMA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define BMA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/bma_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bma_pkg;

  localparam int MEM_BYTES = 1024;
  localparam int LANES     = 4;
  localparam int LANE_W    = 2;
  localparam int ROWS      = MEM_BYTES / LANES;
  localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int ADDR_W    = 16;
  localparam int DATA_W    = 32;
  localparam int CFG_W     = 11;
  localparam int SPAN_W    = ADDR_W + 1;

  localparam logic [CFG_W-1:0]  MEM_SIZE_RESET = 11'd1024;
  localparam logic [ROW_W-1:0]  LAST_ROW       = ROW_W'(ROWS - 1);
  localparam logic [SPAN_W-1:0] STORE_LIMIT    = SPAN_W'(MEM_BYTES);

  typedef enum logic [1:0] {
    SIZE_BYTE = 2'd0,
    SIZE_HALF = 2'd1,
    SIZE_WORD = 2'd2,
    SIZE_RSVD = 2'd3
  } size_code_t;

  typedef enum logic {
    MODE_WRITE = 1'b0,
    MODE_READ  = 1'b1
  } mode_t;

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } seq_state_t;

  // one request to one byte bank
  typedef struct packed {
    logic             we;
    logic             re;
    logic [ROW_W-1:0] row;
    logic [7:0]       wdata;
  } bank_req_t;

  // bytes touched, counted from the lowest address
  function automatic logic [LANES-1:0] lane_mask(input logic [1:0] code);
    logic [LANES-1:0] m;
    case (code)
      SIZE_BYTE: m = 4'b0001;
      SIZE_HALF: m = 4'b0011;
      SIZE_WORD: m = 4'b1111;
      default:   m = 4'b0000;
    endcase
    return m;
  endfunction

  function automatic logic [2:0] access_len(input logic [1:0] code);
    logic [2:0] n;
    case (code)
      SIZE_BYTE: n = 3'd1;
      SIZE_HALF: n = 3'd2;
      SIZE_WORD: n = 3'd4;
      default:   n = 3'd0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/bma_ifs.sv
`timescale 1ns / 1ps
`default_nettype none

interface bma_in_if import bma_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              mode;
  logic [1:0]        size_code;
  logic [ADDR_W-1:0] address;
  logic [DATA_W-1:0] data;

  modport source (output valid, mode, size_code, address, data, input ready);
  modport sink   (input valid, mode, size_code, address, data, output ready);
endinterface

interface bma_out_if import bma_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  logic              violation;

  modport source (output valid, read_data, violation, input ready);
  modport sink   (input valid, read_data, violation, output ready);
endinterface

interface bma_cfg_if import bma_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/bma_bank.sv
`timescale 1ns / 1ps
`default_nettype none

module bma_bank import bma_pkg::*; (
  input  logic       clk,
  input  bank_req_t  req,
  output logic [7:0] rdata
);

  logic [7:0] mem [ROWS];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.row] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[req.row];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: rtl/core/bma_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module bma_ctrl import bma_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  bma_in_if.sink                      in_bus,
  bma_out_if.source                   out_bus,
  input  logic [CFG_W-1:0]            mem_size,
  output bank_req_t [LANES-1:0]       bank_req,
  input  logic [LANES-1:0][7:0]       bank_rdata
);

  seq_state_t       state_r, state_nxt;
  logic [ROW_W-1:0] clr_row_r, clr_row_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic             viol_r;
  logic [LANE_W-1:0] off_r;
  logic [LANES-1:0] rd_mask_r;

  logic              accept;
  logic [SPAN_W-1:0] mem_ext, limit, span_end;
  logic [LANES-1:0]  mask;
  logic              viol;
  logic              is_read;
  logic [LANE_W-1:0] off;
  logic [ROW_W-1:0]  row_base, row_next;

  // clearing sweep, then normal service
  always_comb begin
    state_nxt   = state_r;
    clr_row_nxt = clr_row_r;
    case (state_r)
      ST_CLEAR: begin
        clr_row_nxt = clr_row_r + 1'b1;
        if (clr_row_r == LAST_ROW) begin
          state_nxt   = ST_RUN;
          clr_row_nxt = '0;
        end
      end
      ST_RUN: begin
        state_nxt = ST_RUN;
      end
      default: begin
        state_nxt   = ST_CLEAR;
        clr_row_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_row_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_row_r <= clr_row_nxt;
    end
  end

  assign in_bus.ready = (state_r == ST_RUN) && (!out_valid_r || out_bus.ready);
  assign accept       = in_bus.valid && in_bus.ready;

  // bounds: limit saturates at the physical store
  assign mem_ext  = SPAN_W'(mem_size);
  assign limit    = (mem_ext > STORE_LIMIT) ? STORE_LIMIT : mem_ext;
  assign span_end = SPAN_W'(in_bus.address) + SPAN_W'(access_len(in_bus.size_code));
  assign mask     = lane_mask(in_bus.size_code);
  assign viol     = (mask == '0) || (span_end > limit);
  assign is_read  = (in_bus.mode == MODE_READ);

  assign off      = in_bus.address[LANE_W-1:0];
  assign row_base = in_bus.address[ROW_W+LANE_W-1:LANE_W];
  assign row_next = row_base + 1'b1;

  // lane b carries byte (b - off); lanes below off wrap into the next row
  always_comb begin
    logic [LANE_W-1:0] k;
    for (int b = 0; b < LANES; b++) begin
      k = LANE_W'(b) - off;
      if (state_r == ST_CLEAR) begin
        bank_req[b].we    = 1'b1;
        bank_req[b].re    = 1'b0;
        bank_req[b].row   = clr_row_r;
        bank_req[b].wdata = '0;
      end else begin
        bank_req[b].we    = accept && !viol && !is_read && mask[k];
        bank_req[b].re    = accept && !viol && is_read && mask[k];
        bank_req[b].row   = (LANE_W'(b) < off) ? row_next : row_base;
        bank_req[b].wdata = in_bus.data[{k, 3'b000} +: 8];
      end
    end
  end

  // result stage
  assign out_valid_nxt = accept ? 1'b1 : (out_bus.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      viol_r    <= viol;
      off_r     <= off;
      rd_mask_r <= (is_read && !viol) ? mask : '0;
    end
  end

  always_comb begin
    logic [LANE_W-1:0] src;
    for (int k = 0; k < LANES; k++) begin
      src = off_r + LANE_W'(k);
      out_bus.read_data[8*k +: 8] = rd_mask_r[k] ? bank_rdata[src] : 8'h00;
    end
  end

  assign out_bus.valid     = out_valid_r;
  assign out_bus.violation = viol_r;

endmodule

`default_nettype wire

FILE: rtl/core/byte_memory_sized_access_top.sv
// Byte-addressed memory with 1, 2 or 4 byte little-endian accesses.
//
// in_bus  : one access per beat (mode, size_code, address, data).
// out_bus : one result beat per access (read_data, violation).
// cfg_bus : writes mem_size; always ready. The user must write it only while
// idle; the block itself does not enforce this.
// The result is registered and shown in the cycle after the access beat.
// One access per cycle unless a held result stalls it. The store is four
// byte-wide banks of one read/write port each; an unaligned access spreads
// over two rows, each bank serving exactly one row, so no bank sees two rows.
// A read following a write sees it, as the write lands at the accept edge.
//
// Reset: mem_size returns to 1024 and a clearing sweep zeroes the store,
// one row of four bytes per cycle, all MEM_BYTES/4 = 256 rows; in_bus.ready
// stays low throughout, configuration writes are still taken.
//
// Stall: the result register holds while out_bus.ready is low, and a new
// beat is taken only when its slot is empty or is emptied. Refused accesses
// (out of range or reserved width) write nothing and return zero data.
`timescale 1ns / 1ps
`default_nettype none

module byte_memory_sized_access_top import bma_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  bma_in_if.sink     in_bus,
  bma_out_if.source  out_bus,
  bma_cfg_if.sink    cfg_bus
);

  logic [CFG_W-1:0] mem_size_r, mem_size_nxt;

  bank_req_t [LANES-1:0]  bank_req;
  logic [LANES-1:0][7:0]  bank_rdata;

  // size register: taken on every cfg beat
  assign cfg_bus.ready = 1'b1;
  assign mem_size_nxt  = (cfg_bus.valid && cfg_bus.ready) ? cfg_bus.data : mem_size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_size_r <= MEM_SIZE_RESET;
    end else begin
      mem_size_r <= mem_size_nxt;
    end
  end

  // access decode, clearing sweep and result stage
  bma_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_bus     (in_bus),
    .out_bus    (out_bus),
    .mem_size   (mem_size_r),
    .bank_req   (bank_req),
    .bank_rdata (bank_rdata)
  );

  // byte lane b holds every address with address[1:0] == b
  for (genvar b = 0; b < LANES; b++) begin : g_bank
    bma_bank u_bank (
      .clk   (clk),
      .req   (bank_req[b]),
      .rdata (bank_rdata[b])
    );
  end

endmodule

`default_nettype wire

FILE: rtl/core/bma_chk.sv
`timescale 1ns / 1ps
`default_nettype none
`include "byte_memory_sized_access_top_assert.svh"

module bma_chk import bma_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic [1:0]        in_size_code,
  input logic              out_valid,
  input logic              out_ready,
  input logic [DATA_W-1:0] out_read_data,
  input logic              out_violation
);

  `BMA_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result beat dropped while stalled")
  `BMA_ASSERT(a_beat_result, in_valid && in_ready |=> out_valid, "accepted beat gave no result")
  `BMA_ASSERT(a_rsvd_refused, in_valid && in_ready && (in_size_code == SIZE_RSVD) |=> out_valid && out_violation, "reserved width not refused")
  `BMA_ASSERT(a_viol_zero, out_valid && out_violation |-> out_read_data == '0, "refused access returned data")
  `BMA_ASSERT_ALWAYS(a_clear_blocks, !rst_n |=> !in_ready, "input taken during clearing sweep")

endmodule

bind byte_memory_sized_access_top bma_chk u_bma_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_bus.valid),
  .in_ready      (in_bus.ready),
  .in_size_code  (in_bus.size_code),
  .out_valid     (out_bus.valid),
  .out_ready     (out_bus.ready),
  .out_read_data (out_bus.read_data),
  .out_violation (out_bus.violation)
);

`default_nettype wire
